/* hdl/tksi_pkg.sv */
// ----------------------------------------------------------------------------
// tksi_pkg
// Types and constants shared by the top-k sorted insertion list.
// ----------------------------------------------------------------------------
`default_nettype none

package tksi_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [4:0] MAX_ENTRIES_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] new_score;
    logic [31:0] new_tag;
    logic [3:0]  read_index;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  placed_at;
    logic [4:0]  entry_count;
    logic        read_valid;
    logic [31:0] read_score;
    logic [31:0] read_tag;
  } rsp_t;

  typedef struct packed {
    logic [31:0] score;
    logic [31:0] tag;
  } entry_t;

endpackage

`default_nettype wire

/* hdl/top_k_sorted_insert.sv */
// ----------------------------------------------------------------------------
// top_k_sorted_insert
// Keeps the best-scoring (score, tag) entries in descending score order.
// ----------------------------------------------------------------------------
// The list takes a new entry while it holds fewer than max_entries entries,
// read as 1 when zero and capped at LIST_DEPTH; entries are ranked by unsigned
// Q16.16 score with rank 0 the best; among equal scores the older entry stays
// ahead. The block works on one item at a time and holds req_stall high until
// that item's result is placed in the output register. An insert into a full
// list is first compared with the last entry and is rejected unless its score
// is higher. The insertion walk moves one entry per cycle, as the entry memory
// has a single read port. Each item waits longer while the previous result is
// still stalled in the output register. Clearing only resets the count, so no
// memory sweep is needed after reset. The configuration port is always ready.
`default_nettype none

module top_k_sorted_insert #(
  parameter int LIST_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire tksi_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output tksi_pkg::rsp_t      rsp,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [4:0]     cfg_data
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int HW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_LAST,
    S_SHIFT_RD,
    S_SHIFT_CMP,
    S_PLACE,
    S_RD_WAIT,
    S_FINISH
  } state_t;

  state_t            state;
  logic [HW-1:0]     held_count;
  logic [4:0]        max_entries;
  logic [AW-1:0]     pos;
  logic [31:0]       cur_score;
  logic [31:0]       cur_tag;
  tksi_pkg::rsp_t    res;
  tksi_pkg::rsp_t    rsp_next;
  logic [31:0]       limit;
  logic              req_xfer;
  logic              rsp_free;

  logic              we;
  logic [AW-1:0]     waddr;
  tksi_pkg::entry_t  wdata;
  logic [AW-1:0]     raddr;
  tksi_pkg::entry_t  rdata;

  tksi_store #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req_stall = (state != S_IDLE);
  assign req_xfer  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (max_entries == 5'd0) begin
      limit = 32'd1;
    end else if (32'(max_entries) > 32'(LIST_DEPTH)) begin
      limit = 32'(LIST_DEPTH);
    end else begin
      limit = 32'(max_entries);
    end
  end

  always_comb begin
    rsp_next             = res;
    rsp_next.entry_count = 5'(held_count);
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = rdata;
    raddr = pos - AW'(1);
    case (state)
      S_IDLE: begin
        if (req.cmd == tksi_pkg::CMD_READ) begin
          raddr = AW'(req.read_index);
        end else begin
          raddr = AW'(held_count - HW'(1));
        end
      end
      S_SHIFT_CMP: begin
        if (rdata.score < cur_score) begin
          we    = 1'b1;
          raddr = pos - AW'(2);
        end
      end
      S_PLACE: begin
        we          = 1'b1;
        wdata.score = cur_score;
        wdata.tag   = cur_tag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      held_count  <= '0;
      max_entries <= tksi_pkg::MAX_ENTRIES_RESET;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_entries <= cfg_data;
      end
      if (rsp_valid && !rsp_stall && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            cur_score <= req.new_score;
            cur_tag   <= req.new_tag;
            res       <= '0;
            case (req.cmd)
              tksi_pkg::CMD_INSERT: begin
                if (32'(held_count) < limit) begin
                  pos        <= AW'(held_count);
                  held_count <= held_count + HW'(1);
                  state      <= S_SHIFT_RD;
                end else begin
                  pos   <= AW'(held_count - HW'(1));
                  state <= S_CHK_LAST;
                end
              end
              tksi_pkg::CMD_READ: begin
                if (32'(req.read_index) < 32'(held_count)) begin
                  state <= S_RD_WAIT;
                end else begin
                  state <= S_FINISH;
                end
              end
              tksi_pkg::CMD_CLEAR: begin
                held_count <= '0;
                state      <= S_FINISH;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_CHK_LAST: begin
          if (cur_score <= rdata.score) begin
            state <= S_FINISH;
          end else begin
            state <= S_SHIFT_RD;
          end
        end
        S_SHIFT_RD: begin
          if (pos == '0) begin
            state <= S_PLACE;
          end else begin
            state <= S_SHIFT_CMP;
          end
        end
        S_SHIFT_CMP: begin
          if (rdata.score < cur_score) begin
            pos <= pos - AW'(1);
            if (pos == AW'(1)) begin
              state <= S_PLACE;
            end
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          res.accepted  <= 1'b1;
          res.placed_at <= 4'(pos);
          state         <= S_FINISH;
        end
        S_RD_WAIT: begin
          res.read_valid <= 1'b1;
          res.read_score <= rdata.score;
          res.read_tag   <= rdata.tag;
          state          <= S_FINISH;
        end
        S_FINISH: begin
          if (rsp_free) begin
            rsp       <= rsp_next;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/tksi_store.sv */
// ----------------------------------------------------------------------------
// tksi_store
// Entry memory with one write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tksi_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire tksi_pkg::entry_t wdata,
  input  wire logic [AW-1:0]    raddr,
  output tksi_pkg::entry_t      rdata
);

  tksi_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/tksi_checker.sv */
// ----------------------------------------------------------------------------
// tksi_checker
// Port-level checks for the top-k sorted insertion list, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tksi_checker #(
  parameter int LIST_DEPTH = 16
) (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire tksi_pkg::rsp_t rsp
);

  // A stalled result must hold until its transfer.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_insert_no_read: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.accepted |-> !rsp.read_valid && rsp.entry_count != 5'd0)
    else $error("accepted insert carries read data or an empty list");

  a_invalid_read_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.read_valid |-> rsp.read_score == 32'd0 && rsp.read_tag == 32'd0)
    else $error("read fields not zero without a valid read");

  a_placed_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.accepted && (LIST_DEPTH <= 16) |->
      5'(rsp.placed_at) < rsp.entry_count)
    else $error("accepted entry placed beyond the entry count");

  // The block never takes a new request in the cycle right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while an item is in progress");

endmodule

bind top_k_sorted_insert tksi_checker #(
  .LIST_DEPTH (LIST_DEPTH)
) u_tksi_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

/* sim/top_k_sorted_insert_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_sorted_insert_checker
// Watches the request, result and limit channels of the ranked list and checks
// every result transfer against a shadow copy of the list kept in the checker.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_checker #(
  parameter int LIST_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_stall,
  input  tksi_pkg::req_t   req,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  tksi_pkg::rsp_t   rsp,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [4:0]       cfg_data,
  output int               fail_count,
  output int               outstanding
);

  logic [31:0]    rank_score [LIST_DEPTH];
  logic [31:0]    rank_tag   [LIST_DEPTH];
  int             held_n;
  logic [4:0]     limit_q;
  tksi_pkg::rsp_t owed_results [$];

  function automatic tksi_pkg::rsp_t list_update(input tksi_pkg::req_t item);
    tksi_pkg::rsp_t res;
    int             lim;
    int             pos;
    bit             take;
    res = '0;
    lim = (limit_q == 5'd0) ? 1 :
          ((int'(limit_q) > LIST_DEPTH) ? LIST_DEPTH : int'(limit_q));
    case (item.cmd)
      tksi_pkg::CMD_INSERT: begin
        take = 1'b1;
        if (held_n < lim) begin
          pos = held_n;
          held_n++;
        end else begin
          pos = held_n - 1;
          if (item.new_score <= rank_score[pos]) take = 1'b0;
        end
        if (take) begin
          while (pos > 0 && rank_score[pos - 1] < item.new_score) begin
            rank_score[pos] = rank_score[pos - 1];
            rank_tag[pos]   = rank_tag[pos - 1];
            pos--;
          end
          rank_score[pos] = item.new_score;
          rank_tag[pos]   = item.new_tag;
          res.accepted    = 1'b1;
          res.placed_at   = pos[3:0];
        end
      end
      tksi_pkg::CMD_READ: begin
        if (int'(item.read_index) < held_n) begin
          res.read_valid = 1'b1;
          res.read_score = rank_score[item.read_index];
          res.read_tag   = rank_tag[item.read_index];
        end
      end
      tksi_pkg::CMD_CLEAR: held_n = 0;
      default: ;
    endcase
    res.entry_count = held_n[4:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    tksi_pkg::rsp_t want;
    if (rst) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        rank_score[i] = '0;
        rank_tag[i]   = '0;
      end
      held_n     = 0;
      limit_q    = tksi_pkg::MAX_ENTRIES_RESET;
      fail_count = 0;
      owed_results.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_results.size() == 0) begin
          $error("Result transfer with no request outstanding.");
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("accepted",    32'(want.accepted),    32'(rsp.accepted));
          check_field("placed_at",   32'(want.placed_at),   32'(rsp.placed_at));
          check_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
          check_field("read_valid",  32'(want.read_valid),  32'(rsp.read_valid));
          check_field("read_score",  want.read_score,       rsp.read_score);
          check_field("read_tag",    want.read_tag,         rsp.read_tag);
        end
      end
      if (req_valid && !req_stall) begin
        owed_results.insert(owed_results.size(), list_update(req));
      end
      if (cfg_valid && cfg_ready) limit_q = cfg_data;
    end
    outstanding <= owed_results.size();
  end

endmodule

/* sim/tb_top_k_sorted_insert.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_k_sorted_insert
// Drives the ranked list with directed and random inserts, reads and clears
// under several list limits and handshake pressures; the checker judges.
// ----------------------------------------------------------------------------
module tb_top_k_sorted_insert;

  localparam int         LIST_DEPTH = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic           clk;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  tksi_pkg::req_t req       = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  tksi_pkg::rsp_t rsp;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [4:0]     cfg_data  = '0;
  int             fail_count;
  int             outstanding;
  int             idle_pct  = 0;
  int             stall_pct = 0;

  top_k_sorted_insert #(.LIST_DEPTH(LIST_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  top_k_sorted_insert_checker #(.LIST_DEPTH(LIST_DEPTH)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic tksi_pkg::req_t ins(input logic [31:0] score,
                                         input logic [31:0] tag);
    tksi_pkg::req_t r;
    r = '0;
    r.cmd       = tksi_pkg::CMD_INSERT;
    r.new_score = score;
    r.new_tag   = tag;
    return r;
  endfunction

  function automatic tksi_pkg::req_t rd(input logic [3:0] idx);
    tksi_pkg::req_t r;
    r = '0;
    r.cmd        = tksi_pkg::CMD_READ;
    r.read_index = idx;
    return r;
  endfunction

  function automatic tksi_pkg::req_t op(input logic [1:0] code);
    tksi_pkg::req_t r;
    r = '0;
    r.cmd = code;
    return r;
  endfunction

  // Small whole-number scores give many ties; extremes and full-range values
  // cover the rest.
  function automatic tksi_pkg::req_t random_item();
    tksi_pkg::req_t r;
    int             pick;
    pick         = $urandom_range(99);
    r.cmd        = (pick < 56) ? tksi_pkg::CMD_INSERT :
                   (pick < 93) ? tksi_pkg::CMD_READ :
                   (pick < 96) ? tksi_pkg::CMD_CLEAR : CMD_UNUSED;
    r.new_tag    = $urandom;
    r.read_index = 4'($urandom_range(15));
    case ($urandom_range(9))
      0:       r.new_score = 32'h0000_0000;
      1:       r.new_score = 32'hFFFF_FFFF;
      2, 3, 4: r.new_score = {16'($urandom_range(7)), 16'h0000};
      default: r.new_score = $urandom;
    endcase
    return r;
  endfunction

  task automatic send_item(input tksi_pkg::req_t item);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_limit(input logic [4:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int limits[8];
    limits    = '{16, 1, 31, 0, 4, 17, 16, 0};
    limits[7] = $urandom_range(31);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(rd(4'd0));
    send_item(rd(4'd15));
    send_item(op(CMD_UNUSED));
    send_item(ins(32'h0000_8000, 32'd1));
    send_item(ins(32'h0000_8000, 32'd2));
    send_item(ins(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(ins(32'h0000_0000, 32'h0000_0000));
    send_item(ins(32'h0000_8000, 32'd3));
    send_item(rd(4'd0));
    send_item(rd(4'd2));
    send_item(rd(4'd4));
    send_item(rd(4'd5));
    send_item(op(CMD_UNUSED));
    send_item(op(tksi_pkg::CMD_CLEAR));
    send_item(rd(4'd0));

    // With a single slot, equal or lower scores are turned away.
    write_limit(5'd1);
    send_item(ins(32'h0005_0000, 32'd10));
    send_item(ins(32'h0003_0000, 32'd11));
    send_item(ins(32'h0005_0000, 32'd12));
    send_item(ins(32'h0009_0000, 32'd13));
    send_item(rd(4'd0));

    // Lowering the limit below the count keeps the held entries.
    write_limit(5'd16);
    send_item(ins(32'h0007_0000, 32'd20));
    send_item(ins(32'h0002_0000, 32'd21));
    send_item(ins(32'h0004_0000, 32'd22));
    write_limit(5'd2);
    send_item(ins(32'h0001_0000, 32'd23));
    send_item(ins(32'h0008_0000, 32'd24));
    send_item(rd(4'd3));
    write_limit(5'd0);
    send_item(ins(32'h0003_0000, 32'd25));
    send_item(op(tksi_pkg::CMD_CLEAR));
    send_item(ins(32'h0003_0000, 32'd26));

    for (int p = 0; p < 8; p++) begin
      write_limit(limits[p][4:0]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      repeat (112) send_item(random_item());
    end

    settle();
    repeat (LIST_DEPTH + 5) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("top_k_sorted_insert verification clean");
    end else begin
      $display("top_k_sorted_insert verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("top_k_sorted_insert verification failed");
    $finish;
  end

endmodule
